// ----- hw/rtl/aot_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aot_pkg
// Shared types and constants of the knob adjusted auto-off light timer.
// ----------------------------------------------------------------------------
package aot_pkg;

    // field widths
    localparam int NOW_W   = 32;
    localparam int TKNOB_W = 10;
    localparam int BKNOB_W = 8;
    localparam int NOTE_W  = 2;
    localparam int DUR_W   = 20;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_INIT_TIMEOUT = 1'b0;
    localparam logic [IDX_W-1:0] REG_MAX_TIMEOUT  = 1'b1;

    // register reset values
    localparam logic [DUR_W-1:0]   INIT_TIMEOUT_RST = 20'd60000;
    localparam logic [CFG_W-1:0]   MAX_TIMEOUT_RST  = 32'd999000;
    localparam logic [TKNOB_W-1:0] TPOS_RST         = 10'd60;

    // operating modes; code 3 is unused and acts as normal
    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_TIMEOUT = 2'd1;
    localparam logic [1:0] MODE_BRIGHT  = 2'd2;

    // notice codes
    localparam logic [NOTE_W-1:0] NOTE_NONE    = 2'd0;
    localparam logic [NOTE_W-1:0] NOTE_TIMEOUT = 2'd1;
    localparam logic [NOTE_W-1:0] NOTE_BRIGHT  = 2'd2;

    // one input beat
    typedef struct packed {
        logic [NOW_W-1:0]   now_ms;
        logic [TKNOB_W-1:0] timeout_knob;
        logic [BKNOB_W-1:0] brightness_knob;
        logic               wake_event;
    } t_item;

    // one result beat
    typedef struct packed {
        logic               updated;
        logic               light_on;
        logic [NOTE_W-1:0]  change_notice;
        logic [NOTE_W-1:0]  end_notice;
        logic [TKNOB_W-1:0] notice_value;
    } t_result;

    // setup values pushed to the core on a register write
    typedef struct packed {
        logic               apply;
        logic [DUR_W-1:0]   off_duration;
        logic [TKNOB_W-1:0] timeout_pos;
    } t_setup;

endpackage

// ----- hw/rtl/aot_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aot_in_if
// Input channel: timestamp, knob positions and wake flag.
// ----------------------------------------------------------------------------
interface aot_in_if;
    logic                          valid;
    logic                          ready;
    logic [aot_pkg::NOW_W-1:0]     now_ms;
    logic [aot_pkg::TKNOB_W-1:0]   timeout_knob;
    logic [aot_pkg::BKNOB_W-1:0]   brightness_knob;
    logic                          wake_event;

    modport source (output valid, now_ms, timeout_knob, brightness_knob, wake_event,
                    input ready);
    modport sink (input valid, now_ms, timeout_knob, brightness_knob, wake_event,
                  output ready);
endinterface

// ----- hw/rtl/aot_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aot_out_if
// Result channel: update flag, light state and notices.
// ----------------------------------------------------------------------------
interface aot_out_if;
    logic                          valid;
    logic                          ready;
    logic                          updated;
    logic                          light_on;
    logic [aot_pkg::NOTE_W-1:0]    change_notice;
    logic [aot_pkg::NOTE_W-1:0]    end_notice;
    logic [aot_pkg::TKNOB_W-1:0]   notice_value;

    modport source (output valid, updated, light_on, change_notice, end_notice,
                    notice_value, input ready);
    modport sink (input valid, updated, light_on, change_notice, end_notice,
                  notice_value, output ready);
endinterface

// ----- hw/rtl/aot_setup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aot_setup
// Configuration registers and derivation of the auto-off duration and the
// seeded timeout knob position.
// ----------------------------------------------------------------------------
module aot_setup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [aot_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [aot_pkg::CFG_W-1:0]     i_cfg_wdata,
    output aot_pkg::t_setup               o_setup
);
    import aot_pkg::*;

    // x / 1000 == (x * RECIP) >> RSH, exact for any 20-bit x
    localparam int               RSH    = 30;
    localparam logic [20:0]      RECIP  = 21'd1073742;
    localparam logic [CFG_W-1:0] CAP_LIM = 32'd1000000;
    localparam logic [CFG_W-1:0] CAP_VAL = 32'd999000;
    localparam logic [10:0]      POS_MAX = 11'd1023;

    logic [DUR_W-1:0] r_init, n_init;
    logic [CFG_W-1:0] r_max, n_max;
    logic             hit;
    logic [40:0]      prod;
    logic [10:0]      quot;
    logic [CFG_W-1:0] cap;

    // register write decode
    always_comb begin
        n_init = r_init;
        n_max  = r_max;
        hit    = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INIT_TIMEOUT: begin
                    n_init = i_cfg_wdata[DUR_W-1:0];
                    hit    = 1'b1;
                end
                REG_MAX_TIMEOUT: begin
                    n_max = i_cfg_wdata;
                    hit   = 1'b1;
                end
                default: hit = 1'b0;
            endcase
        end
    end

    // derived setup values from the new register contents
    always_comb begin
        prod = {21'd0, n_init} * {20'd0, RECIP};
        quot = prod[RSH+10:RSH];
        cap  = (n_max >= CAP_LIM) ? CAP_VAL : n_max;
        o_setup.apply        = hit;
        o_setup.timeout_pos  = (quot > POS_MAX) ? POS_MAX[TKNOB_W-1:0] : quot[TKNOB_W-1:0];
        o_setup.off_duration = ({12'd0, n_init} > cap) ? cap[DUR_W-1:0] : n_init;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= INIT_TIMEOUT_RST;
            r_max  <= MAX_TIMEOUT_RST;
        end else begin
            r_init <= n_init;
            r_max  <= n_max;
        end
    end

endmodule

// ----- hw/rtl/aot_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aot_core
// Timer state and the per-beat update: elapsed time, mode handling, knob
// notices and the auto-off decision.
// ----------------------------------------------------------------------------
module aot_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  aot_pkg::t_item  i_item,
    input  logic            i_fire,
    input  aot_pkg::t_setup i_setup,
    output aot_pkg::t_result o_result
);
    import aot_pkg::*;

    localparam logic [NOW_W-1:0] MIN_STEP     = 32'd50;
    localparam logic [NOW_W-1:0] SET_WINDOW   = 32'd5000;
    localparam logic [9:0]       MS_PER_S     = 10'd1000;

    logic [NOW_W-1:0]   r_last_time, n_last_time;
    logic [NOW_W-1:0]   r_count, n_count;
    logic [1:0]         r_mode, n_mode;
    logic [TKNOB_W-1:0] r_tpos, n_tpos;
    logic [BKNOB_W-1:0] r_bpos, n_bpos;
    logic [DUR_W-1:0]   r_off, n_off;
    logic               r_light, n_light;

    logic [NOW_W-1:0]   delta;
    logic [NOW_W-1:0]   sum;
    logic               act;
    logic               tchg;
    logic               bchg;
    logic [DUR_W-1:0]   knob_ms;
    logic [NOTE_W-1:0]  chg;
    logic [NOTE_W-1:0]  endn;
    logic [TKNOB_W-1:0] val;

    // step logic
    always_comb begin
        delta   = i_item.now_ms - r_last_time;
        act     = delta >= MIN_STEP;
        sum     = r_count + delta;
        tchg    = i_item.timeout_knob != r_tpos;
        bchg    = i_item.brightness_knob != r_bpos;
        knob_ms = {10'd0, i_item.timeout_knob} * {10'd0, MS_PER_S};

        n_last_time = r_last_time;
        n_count     = r_count;
        n_mode      = r_mode;
        n_tpos      = r_tpos;
        n_bpos      = r_bpos;
        n_off       = r_off;
        n_light     = r_light;
        chg         = NOTE_NONE;
        endn        = NOTE_NONE;
        val         = '0;

        if (i_fire && act) begin
            n_last_time = i_item.now_ms;
            n_count     = sum;
            case (r_mode)
                MODE_TIMEOUT: begin
                    if (tchg) begin
                        n_count = '0;
                        n_tpos  = i_item.timeout_knob;
                        n_off   = knob_ms;
                        chg     = NOTE_TIMEOUT;
                        val     = i_item.timeout_knob;
                    end
                    if (n_count > SET_WINDOW) begin
                        n_mode  = MODE_NORMAL;
                        n_count = '0;
                        endn    = NOTE_TIMEOUT;
                        val     = n_tpos;
                    end
                end
                MODE_BRIGHT: begin
                    if (bchg) begin
                        n_count = '0;
                        n_bpos  = i_item.brightness_knob;
                        chg     = NOTE_BRIGHT;
                        val     = {2'd0, i_item.brightness_knob};
                    end
                    if (n_count > SET_WINDOW) begin
                        n_mode  = MODE_NORMAL;
                        n_count = '0;
                        endn    = NOTE_BRIGHT;
                        val     = {2'd0, i_item.brightness_knob};
                    end
                end
                default: begin
                    // normal mode; the unused code behaves the same
                    if (tchg) begin
                        n_mode  = MODE_TIMEOUT;
                        n_count = '0;
                        n_tpos  = i_item.timeout_knob;
                    end else if (bchg) begin
                        n_mode  = MODE_BRIGHT;
                        n_count = '0;
                        n_bpos  = i_item.brightness_knob;
                    end
                    if (i_item.wake_event) begin
                        n_count = '0;
                    end
                    if (n_count > {12'd0, r_off}) begin
                        n_light = 1'b0;
                        n_count = {12'd0, r_off} + MIN_STEP;
                    end else begin
                        n_light = 1'b1;
                    end
                end
            endcase
        end

        // register write re-applies setup
        if (i_setup.apply) begin
            n_off  = i_setup.off_duration;
            n_tpos = i_setup.timeout_pos;
            if (r_mode == MODE_TIMEOUT) begin
                n_mode = MODE_NORMAL;
            end
        end

        o_result.updated       = i_fire && act;
        o_result.light_on      = n_light;
        o_result.change_notice = chg;
        o_result.end_notice    = endn;
        o_result.notice_value  = val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_count     <= '0;
            r_mode      <= MODE_NORMAL;
            r_tpos      <= TPOS_RST;
            r_bpos      <= '0;
            r_off       <= INIT_TIMEOUT_RST;
            r_light     <= 1'b0;
        end else begin
            r_last_time <= n_last_time;
            r_count     <= n_count;
            r_mode      <= n_mode;
            r_tpos      <= n_tpos;
            r_bpos      <= n_bpos;
            r_off       <= n_off;
            r_light     <= n_light;
        end
    end

    // an acting beat moves the reference time to its timestamp
    a_time_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && act |=> r_last_time == $past(i_item.now_ms))
        else $error("last update time not taken from acting beat");

    // an early beat leaves the count alone
    a_early_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !act |=> r_count == $past(r_count))
        else $error("count changed on an early beat");

    // the light only goes off on an acting beat
    a_light_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_light) |-> $past(i_fire && act))
        else $error("light went off without an acting beat");

    // an end notice returns the block to normal mode
    a_end_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (endn != NOTE_NONE) |=> r_mode == MODE_NORMAL)
        else $error("end notice without return to normal mode");

endmodule

// ----- hw/rtl/knob_adjusted_auto_off_timer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knob_adjusted_auto_off_timer_top
// Auto-off light timer with knob adjustment: input register, timer core,
// setup registers and result register.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    now_ms, timeout_knob, brightness_knob, wake_event
//  o_out     out  valid/ready    updated, light_on, change_notice, end_notice,
//                                notice_value
//  i_cfg_*   in   write enable   i_cfg_idx, i_cfg_wdata
//
//  One result beat per input beat, through the input register and then the
//  result register. Sustained rate is one beat per cycle while o_out.ready
//  stays high; the single update stage between these two registers sets it.
//  Synchronous active-low reset; no clearing pass, ready right after reset.
//  A stalled result register holds the input register, which then drops ready.
// ----------------------------------------------------------------------------
module knob_adjusted_auto_off_timer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    aot_in_if.sink                        i_in,
    aot_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [aot_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [aot_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import aot_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    proc_ready;
    logic    proc_fire;
    t_result result;
    t_setup  setup;

    // handshake control
    assign proc_ready = !r_out_valid || o_out.ready;
    assign proc_fire  = r_in_valid && proc_ready;
    assign i_in.ready = !r_in_valid || proc_fire;

    aot_setup u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_setup     (setup)
    );

    aot_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (r_in),
        .i_fire   (proc_fire),
        .i_setup  (setup),
        .o_result (result)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (proc_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.now_ms          <= i_in.now_ms;
            r_in.timeout_knob    <= i_in.timeout_knob;
            r_in.brightness_knob <= i_in.brightness_knob;
            r_in.wake_event      <= i_in.wake_event;
        end
        if (proc_fire) begin
            r_out <= result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.updated       = r_out.updated;
    assign o_out.light_on      = r_out.light_on;
    assign o_out.change_notice = r_out.change_notice;
    assign o_out.end_notice    = r_out.end_notice;
    assign o_out.notice_value  = r_out.notice_value;

endmodule
